@@ src/tes_pkg.sv @@
package tes_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int KEY_W        = 51;

    localparam logic [2:0] OP_AT     = 3'd0;
    localparam logic [2:0] OP_AFTER  = 3'd1;
    localparam logic [2:0] OP_CYCLES = 3'd2;
    localparam logic [2:0] OP_CANCEL = 3'd3;
    localparam logic [2:0] OP_POP    = 3'd4;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_PAST       = 3'd1;
    localparam logic [2:0] ST_OVERFLOW   = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND  = 3'd3;
    localparam logic [2:0] ST_EMPTY      = 3'd4;
    localparam logic [2:0] ST_NOT_DUE    = 3'd5;
    localparam logic [2:0] ST_FULL       = 3'd6;
    localparam logic [2:0] ST_BAD_PERIOD = 3'd7;

    // Request to the shared multiply/divide unit.
    typedef struct packed {
        logic        start;
        logic        mul;
        logic [63:0] a;
        logic [63:0] b;
    } t_md_req;

endpackage

@@ src/tes_muldiv.sv @@
module tes_muldiv (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tes_pkg::t_md_req i_req,
    output logic             o_done,
    output logic [63:0]      o_q,
    output logic [63:0]      o_r
);
    import tes_pkg::*;

    logic        r_busy;
    logic        r_mul;
    logic [5:0]  r_cnt;
    logic [63:0] r_a;
    logic [63:0] r_b;
    logic [64:0] r_rem;
    logic [63:0] r_q;
    logic        r_done;

    logic [64:0] w_shift;
    logic [64:0] w_x;
    logic [64:0] w_y;
    logic [65:0] w_sum;

    // One adder serves both the divide (trial subtract) and the multiply (accumulate).
    always_comb begin
        w_shift = {r_rem[63:0], r_a[63]};
        w_x     = r_mul ? {1'b0, r_q} : w_shift;
        w_y     = r_mul ? {1'b0, r_b} : ~{1'b0, r_b};
        w_sum   = {1'b0, w_x} + {1'b0, w_y} + {65'd0, ~r_mul};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_mul  <= i_req.mul;
                r_a    <= i_req.a;
                r_b    <= i_req.b;
                r_rem  <= '0;
                r_q    <= '0;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_mul) begin
                    if (r_a[0]) begin
                        r_q <= w_sum[63:0];
                    end
                    r_a <= {1'b0, r_a[63:1]};
                    r_b <= {r_b[62:0], 1'b0};
                end else begin
                    r_rem <= w_sum[65] ? w_sum[64:0] : w_shift;
                    r_q   <= {r_q[62:0], w_sum[65]};
                    r_a   <= {r_a[62:0], 1'b0};
                end
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q;
    assign o_r    = r_rem[63:0];

endmodule

@@ src/tes_slots.sv @@
module tes_slots #(
    parameter int CAPACITY = tes_pkg::CAPACITY_DEF,
    parameter int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_we,
    input  logic                     i_clr,
    input  logic [AW-1:0]            i_widx,
    input  logic [63:0]              i_time,
    input  logic [tes_pkg::KEY_W-1:0] i_key,
    input  logic [AW-1:0]            i_raddr,
    output logic                     o_valid,
    output logic [63:0]              o_time,
    output logic [tes_pkg::KEY_W-1:0] o_key
);
    import tes_pkg::*;

    logic [CAPACITY-1:0] r_valid;
    logic [63:0]         r_time_mem [CAPACITY];
    logic [KEY_W-1:0]    r_key_mem  [CAPACITY];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            o_valid <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_widx] <= 1'b1;
            end else if (i_clr) begin
                r_valid[i_widx] <= 1'b0;
            end
            o_valid <= r_valid[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_time_mem[i_widx] <= i_time;
            r_key_mem[i_widx]  <= i_key;
        end
        o_time <= r_time_mem[i_raddr];
        o_key  <= r_key_mem[i_raddr];
    end

endmodule

@@ src/timed_event_scheduler.sv @@
// Timed event scheduler: a table of pending events and a current time.
// Command channel: drive the op and its operands together with start; the
// command is taken at a rising edge where start is high and busy is low.
// Operands are captured then and may change afterward.
// Result channel: o_done is high for exactly one cycle with the status and
// event fields; the receiver cannot stall it and must take it that cycle.
// o_current_time always shows the engine time after the last command.
// Schedule at/after, cancel and pop walk all CAPACITY slots of the table
// memory one per cycle. Schedule by cycles also runs two 64-step divisions
// and a 64-step shift-add multiply on the shared multiply/divide unit.
// A bad period, an overflow after a delay, a past time and an unknown op
// finish without a walk; their result is registered as the command is taken.
// Only one command is in work at a time; busy covers all of it.
// Reset (synchronous, active low) clears the time, sets the next id to one
// and marks every slot free at once; a command may follow right away.
module timed_event_scheduler #(
    parameter int CAPACITY = tes_pkg::CAPACITY_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         i_op,
    input  logic [63:0]        i_time_value,
    input  logic [63:0]        i_cycle_count,
    input  logic [63:0]        i_clock_period,
    input  logic [2:0]         i_phase,
    input  logic signed [15:0] i_priority_req,
    input  logic [31:0]        i_target_id,
    output logic               o_done,
    output logic [2:0]         o_status,
    output logic [31:0]        o_event_id,
    output logic [63:0]        o_event_time,
    output logic [2:0]         o_event_phase,
    output logic signed [15:0] o_event_priority,
    output logic [63:0]        o_current_time
);
    import tes_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    typedef enum logic [3:0] {
        S_IDLE, S_DIV_REM, S_EDGE, S_LIM_GO, S_DIV_LIM, S_MUL, S_SCAN, S_FINISH
    } t_state;

    t_state r_state;

    logic [63:0] r_et;
    logic [31:0] r_id;
    logic [2:0]  r_op;
    logic [63:0] r_tv;
    logic [63:0] r_cyc;
    logic [63:0] r_per;
    logic [2:0]  r_phase;
    logic [15:0] r_prio;
    logic [31:0] r_tid;
    logic [63:0] r_tgt;
    logic [63:0] r_gap;

    logic [AW-1:0] r_cnt;
    logic          r_issue;
    logic          r_rd_vld;
    logic          r_rd_last;
    logic [AW-1:0] r_rd_idx;
    logic          r_found;
    logic [AW-1:0] r_best_idx;
    logic [63:0]   r_best_time;
    logic [KEY_W-1:0] r_best_key;

    logic              r_done;
    logic [2:0]        r_status;
    logic [31:0]       r_ev_id;
    logic [63:0]       r_ev_time;
    logic [2:0]        r_ev_phase;
    logic [15:0]       r_ev_prio;

    t_md_req     w_req;
    logic        w_md_done;
    logic [63:0] w_md_q;
    logic [63:0] w_md_r;

    logic             w_s_valid;
    logic [63:0]      w_s_time;
    logic [KEY_W-1:0] w_s_key;
    logic             w_we;
    logic             w_clr;
    logic [64:0]      w_after;
    logic [64:0]      w_edge;
    logic             w_is_sched;
    logic             w_better;

    assign w_after    = {1'b0, r_et} + {1'b0, i_time_value};
    assign w_edge     = {1'b0, r_et} + {1'b0, r_gap};
    assign w_is_sched = (r_op == OP_AT) || (r_op == OP_AFTER) || (r_op == OP_CYCLES);
    assign w_better   = !r_found || (w_s_time < r_best_time) ||
                        ((w_s_time == r_best_time) && (w_s_key < r_best_key));

    always_comb begin
        w_req = '0;
        case (r_state)
            S_IDLE: begin
                w_req.start = start && (i_op == OP_CYCLES) && (i_clock_period != 64'd0);
                w_req.a     = r_et;
                w_req.b     = i_clock_period;
            end
            S_LIM_GO: begin
                w_req.start = 1'b1;
                w_req.a     = ~r_tgt;
                w_req.b     = r_per;
            end
            S_DIV_LIM: begin
                w_req.start = w_md_done && !(r_cyc > w_md_q);
                w_req.mul   = 1'b1;
                w_req.a     = r_cyc;
                w_req.b     = r_per;
            end
            default: begin
                w_req = '0;
            end
        endcase
    end

    assign w_we  = (r_state == S_FINISH) && w_is_sched && r_found;
    assign w_clr = (r_state == S_FINISH) && r_found &&
                   ((r_op == OP_CANCEL) || ((r_op == OP_POP) && !(r_best_time > r_tv)));

    tes_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_done  (w_md_done),
        .o_q     (w_md_q),
        .o_r     (w_md_r)
    );

    tes_slots #(
        .CAPACITY (CAPACITY),
        .AW       (AW)
    ) u_slots (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_we),
        .i_clr   (w_clr),
        .i_widx  (r_best_idx),
        .i_time  (r_tgt),
        .i_key   ({r_phase, ~r_prio[15], r_prio[14:0], r_id}),
        .i_raddr (r_cnt),
        .o_valid (w_s_valid),
        .o_time  (w_s_time),
        .o_key   (w_s_key)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_et     <= '0;
            r_id     <= 32'd1;
            r_done   <= 1'b0;
            r_issue  <= 1'b0;
            r_rd_vld <= 1'b0;
            r_found  <= 1'b0;
            r_cnt    <= '0;
            r_status <= ST_OK;
            r_ev_id    <= '0;
            r_ev_time  <= '0;
            r_ev_phase <= '0;
            r_ev_prio  <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_op    <= i_op;
                        r_tv    <= i_time_value;
                        r_cyc   <= i_cycle_count;
                        r_per   <= i_clock_period;
                        r_phase <= i_phase;
                        r_prio  <= i_priority_req;
                        r_tid   <= i_target_id;
                        r_tgt   <= i_time_value;
                        r_cnt   <= '0;
                        r_issue <= 1'b1;
                        r_found <= 1'b0;
                        r_rd_vld   <= 1'b0;
                        r_ev_id    <= '0;
                        r_ev_time  <= '0;
                        r_ev_phase <= '0;
                        r_ev_prio  <= '0;
                        r_status   <= ST_OK;
                        case (i_op)
                            OP_AT: begin
                                if (i_time_value < r_et) begin
                                    r_status <= ST_PAST;
                                    r_done   <= 1'b1;
                                end else begin
                                    r_state <= S_SCAN;
                                end
                            end
                            OP_AFTER: begin
                                if (w_after[64]) begin
                                    r_status <= ST_OVERFLOW;
                                    r_done   <= 1'b1;
                                end else begin
                                    r_tgt   <= w_after[63:0];
                                    r_state <= S_SCAN;
                                end
                            end
                            OP_CYCLES: begin
                                if (i_clock_period == 64'd0) begin
                                    r_status <= ST_BAD_PERIOD;
                                    r_done   <= 1'b1;
                                end else begin
                                    r_state <= S_DIV_REM;
                                end
                            end
                            OP_CANCEL, OP_POP: begin
                                r_state <= S_SCAN;
                            end
                            default: begin
                                r_done <= 1'b1;
                            end
                        endcase
                    end
                end
                S_DIV_REM: begin
                    if (w_md_done) begin
                        if (w_md_r == 64'd0) begin
                            r_tgt   <= r_et;
                            r_state <= S_LIM_GO;
                        end else begin
                            r_gap   <= r_per - w_md_r;
                            r_state <= S_EDGE;
                        end
                    end
                end
                S_EDGE: begin
                    // Rounding up to the next period edge must itself fit in 64 bits.
                    if (w_edge[64]) begin
                        r_status <= ST_OVERFLOW;
                        r_done   <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_tgt   <= w_edge[63:0];
                        r_state <= S_LIM_GO;
                    end
                end
                S_LIM_GO: begin
                    r_state <= S_DIV_LIM;
                end
                S_DIV_LIM: begin
                    if (w_md_done) begin
                        if (r_cyc > w_md_q) begin
                            r_status <= ST_OVERFLOW;
                            r_done   <= 1'b1;
                            r_state  <= S_IDLE;
                        end else begin
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    // The limit check guarantees the product and the sum fit.
                    if (w_md_done) begin
                        r_tgt   <= r_tgt + w_md_q;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_issue) begin
                        if (r_cnt == AW'(CAPACITY - 1)) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_cnt <= r_cnt + AW'(1);
                        end
                    end
                    r_rd_vld  <= r_issue;
                    r_rd_idx  <= r_cnt;
                    r_rd_last <= (r_cnt == AW'(CAPACITY - 1));
                    if (r_rd_vld) begin
                        if (w_is_sched) begin
                            if (!r_found && !w_s_valid) begin
                                r_found    <= 1'b1;
                                r_best_idx <= r_rd_idx;
                            end
                        end else if (r_op == OP_CANCEL) begin
                            if (!r_found && w_s_valid && (w_s_key[31:0] == r_tid)) begin
                                r_found    <= 1'b1;
                                r_best_idx <= r_rd_idx;
                            end
                        end else begin
                            if (w_s_valid && w_better) begin
                                r_found     <= 1'b1;
                                r_best_idx  <= r_rd_idx;
                                r_best_time <= w_s_time;
                                r_best_key  <= w_s_key;
                            end
                        end
                        if (r_rd_last) begin
                            r_state  <= S_FINISH;
                        end
                    end
                end
                S_FINISH: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                    if (w_is_sched) begin
                        if (r_found) begin
                            r_ev_id   <= r_id;
                            r_ev_time <= r_tgt;
                            r_id      <= r_id + 32'd1;
                        end else begin
                            r_status <= ST_FULL;
                        end
                    end else if (r_op == OP_CANCEL) begin
                        if (r_found) begin
                            r_ev_id <= r_tid;
                        end else begin
                            r_status <= ST_NOT_FOUND;
                        end
                    end else begin
                        if (!r_found) begin
                            r_status <= ST_EMPTY;
                        end else if (r_best_time > r_tv) begin
                            r_status <= ST_NOT_DUE;
                        end else begin
                            r_et       <= r_best_time;
                            r_ev_id    <= r_best_key[31:0];
                            r_ev_time  <= r_best_time;
                            r_ev_phase <= r_best_key[50:48];
                            r_ev_prio  <= {~r_best_key[47], r_best_key[46:32]};
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy             = (r_state != S_IDLE);
    assign o_done           = r_done;
    assign o_status         = r_status;
    assign o_event_id       = r_ev_id;
    assign o_event_time     = r_ev_time;
    assign o_event_phase    = r_ev_phase;
    assign o_event_priority = r_ev_prio;
    assign o_current_time   = r_et;

endmodule

@@ src/tes_checker.sv @@
module tes_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_done,
    input logic [2:0]  o_status,
    input logic [31:0] o_event_id,
    input logic [63:0] o_current_time
);
    import tes_pkg::*;

    // A result is only shown once the command has left the busy period.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result shown while busy");

    // A taken command either finishes at once or holds busy.
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_done))
        else $error("command neither started nor finished");

    // The engine time moves only with a result transfer.
    a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(o_current_time) |-> o_done)
        else $error("current time changed without a result");

    // A refused command never reports an id.
    a_err_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != ST_OK)) |-> (o_event_id == 32'd0))
        else $error("error result carries an id");

endmodule

bind timed_event_scheduler tes_checker u_tes_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_done         (o_done),
    .o_status       (o_status),
    .o_event_id     (o_event_id),
    .o_current_time (o_current_time)
);
